@@ design/modular_exponentiation_core_macros.svh @@
// Assertion macros for the modular exponentiation core.
// Used by design/modular_exponentiation_core.sv; no other dependencies.
`ifndef MODULAR_EXPONENTIATION_CORE_MACROS_SVH
`define MODULAR_EXPONENTIATION_CORE_MACROS_SVH

// Check a property on every rising clock edge outside of reset
`define MEXP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every rising clock edge, reset included
`define MEXP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ design/mexp_pkg.sv @@
// Shared types and constants for the modular exponentiation core.
// No dependencies; compiled before the channel interfaces and the core.
package mexp_pkg;

   // Fixed field and configuration port widths
   localparam int MSG_WIDTH      = 32;
   localparam int RESULT_WIDTH   = 32;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 3;

   // Datapath width default and register reset values
   localparam int WORD_WIDTH_DEF = 32;
   localparam int MODULUS_RESET  = 2;
   localparam int EXPONENT_RESET = 1;

   // Register index, taken from the word address bit
   typedef enum logic [0:0] {
      REG_MODULUS  = 1'b0,
      REG_EXPONENT = 1'b1
   } mexp_reg_type;

   // Sequencer state
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DBL,
      ST_ADD,
      ST_DONE
   } mexp_state_type;

   // Which modular product the sequencer is working on
   typedef enum logic [1:0] {
      PH_REDUCE,
      PH_SQUARE,
      PH_MULT
   } mexp_phase_type;

endpackage

@@ design/mexp_req_if.sv @@
// Request channel: valid/ready handshake carrying one message word.
// Depends on mexp_pkg for the field width.
interface mexp_req_if;
   logic                                valid;
   logic                                ready;
   logic [mexp_pkg::MSG_WIDTH-1:0]      message;

   modport source (output valid, output message, input ready);
   modport sink   (input valid, input message, output ready);
endinterface

@@ design/mexp_rsp_if.sv @@
// Response channel: valid/ready handshake carrying one result word.
// Depends on mexp_pkg for the field width.
interface mexp_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [mexp_pkg::RESULT_WIDTH-1:0]   result;

   modport source (output valid, output result, input ready);
   modport sink   (input valid, input result, output ready);
endinterface

@@ design/modular_exponentiation_core.sv @@
// Modular exponentiation core: result = message ** exponent mod modulus.
// Depends on mexp_pkg, mexp_req_if, mexp_rsp_if and the macros header.
//
//   Channel   Direction  Transfer               Payload
//   req_ch    in         valid & ready          message
//   rsp_ch    out        valid & ready          result
//   csr_*     in (APB)   psel&penable&pwrite    modulus @0x0, exponent @0x4
//
// Each item runs on the single modular adder (W = WORD_WIDTH): one
// double-or-add step per cycle, W bits per modular product, one square per
// exponent bit plus one multiply per set exponent bit, after a first pass
// that reduces the message. A modulus below 2 answers 0.
// Reset is synchronous; the core takes no request until the result has
// been transferred, and holds the result while rsp_ch.ready is low.
`include "modular_exponentiation_core_macros.svh"

module modular_exponentiation_core #(
   parameter int WORD_WIDTH = mexp_pkg::WORD_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   mexp_req_if.sink                             req_ch,
   mexp_rsp_if.source                           rsp_ch,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [mexp_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [mexp_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [mexp_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                 csr_pready
);

   localparam int CNT_W = $clog2(WORD_WIDTH);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_WIDTH - 1);
   localparam logic [WORD_WIDTH-1:0] WORD_ONE  = WORD_WIDTH'(1);
   localparam logic [WORD_WIDTH-1:0] WORD_ZERO = '0;
   localparam logic [WORD_WIDTH-1:0] WORD_TWO  = WORD_WIDTH'(2);

   // Configuration registers
   logic [WORD_WIDTH-1:0]     modulus_ff;
   logic [WORD_WIDTH-1:0]     exponent_ff;

   // Sequencer and datapath registers
   mexp_pkg::mexp_state_type  state_ff, state_in;
   mexp_pkg::mexp_phase_type  phase_ff, phase_in;
   logic [WORD_WIDTH-1:0]     prod_ff, prod_in;
   logic [WORD_WIDTH-1:0]     mul_a_ff, mul_a_in;
   logic [WORD_WIDTH-1:0]     mul_b_ff, mul_b_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [WORD_WIDTH-1:0]     exp_ff, exp_in;
   logic [CNT_W-1:0]          exp_cnt_ff, exp_cnt_in;
   logic [WORD_WIDTH-1:0]     base_ff, base_in;
   logic [WORD_WIDTH-1:0]     result_ff, result_in;

   // Width adaption between port fields and the datapath
   logic [WORD_WIDTH+mexp_pkg::MSG_WIDTH-1:0]       msg_wide;
   logic [WORD_WIDTH+mexp_pkg::CSR_DATA_WIDTH-1:0]  wdata_wide;
   logic [WORD_WIDTH+mexp_pkg::CSR_DATA_WIDTH-1:0]  modulus_wide;
   logic [WORD_WIDTH+mexp_pkg::CSR_DATA_WIDTH-1:0]  exponent_wide;
   logic [WORD_WIDTH+mexp_pkg::RESULT_WIDTH-1:0]    result_wide;
   logic [WORD_WIDTH-1:0]     msg_word;
   logic [WORD_WIDTH-1:0]     wdata_word;

   // Shared modular adder
   logic [WORD_WIDTH-1:0]     addend;
   logic [WORD_WIDTH:0]       sum;
   logic [WORD_WIDTH:0]       diff;
   logic [WORD_WIDTH-1:0]     unit_out;

   // Sequencer status
   logic                      csr_write;
   logic                      mul_bit;
   logic                      bit_last;
   logic                      exp_bit;
   logic                      exp_last;
   logic                      mul_done;
   logic                      all_done;
   logic                      modulus_small;

   assign msg_wide      = {{WORD_WIDTH{1'b0}}, req_ch.message};
   assign msg_word      = msg_wide[WORD_WIDTH-1:0];
   assign wdata_wide    = {{WORD_WIDTH{1'b0}}, csr_pwdata};
   assign wdata_word    = wdata_wide[WORD_WIDTH-1:0];
   assign modulus_wide  = {{mexp_pkg::CSR_DATA_WIDTH{1'b0}}, modulus_ff};
   assign exponent_wide = {{mexp_pkg::CSR_DATA_WIDTH{1'b0}}, exponent_ff};
   assign result_wide   = {{mexp_pkg::RESULT_WIDTH{1'b0}}, result_ff};

   // Configuration write and read back
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff  <= WORD_WIDTH'(mexp_pkg::MODULUS_RESET);
         exponent_ff <= WORD_WIDTH'(mexp_pkg::EXPONENT_RESET);
      end else if (csr_write) begin
         case (mexp_pkg::mexp_reg_type'(csr_paddr[2]))
            mexp_pkg::REG_MODULUS:  modulus_ff  <= wdata_word;
            mexp_pkg::REG_EXPONENT: exponent_ff <= wdata_word;
            default:                modulus_ff  <= modulus_ff;
         endcase
      end
   end

   always_comb begin
      case (mexp_pkg::mexp_reg_type'(csr_paddr[2]))
         mexp_pkg::REG_MODULUS:  csr_prdata = modulus_wide[mexp_pkg::CSR_DATA_WIDTH-1:0];
         mexp_pkg::REG_EXPONENT: csr_prdata = exponent_wide[mexp_pkg::CSR_DATA_WIDTH-1:0];
         default:                csr_prdata = '0;
      endcase
   end

   // Modular add of two values below the modulus: double, or add operand a
   assign addend   = (state_ff == mexp_pkg::ST_ADD) ? mul_a_ff : prod_ff;
   assign sum      = {1'b0, prod_ff} + {1'b0, addend};
   assign diff     = sum - {1'b0, modulus_ff};
   assign unit_out = (sum >= {1'b0, modulus_ff}) ? diff[WORD_WIDTH-1:0]
                                                 : sum[WORD_WIDTH-1:0];

   // Sequencer status
   assign mul_bit       = mul_b_ff[WORD_WIDTH-1];
   assign bit_last      = (cnt_ff == '0);
   assign exp_bit       = exp_ff[WORD_WIDTH-1];
   assign exp_last      = (exp_cnt_ff == '0);
   assign modulus_small = (modulus_ff < WORD_TWO);

   always_comb begin
      mul_done = bit_last &&
                 (((state_ff == mexp_pkg::ST_DBL) && !mul_bit) ||
                  (state_ff == mexp_pkg::ST_ADD));
      all_done = mul_done && exp_last &&
                 (((phase_ff == mexp_pkg::PH_SQUARE) && !exp_bit) ||
                  (phase_ff == mexp_pkg::PH_MULT));
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mexp_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               state_in = modulus_small ? mexp_pkg::ST_DONE : mexp_pkg::ST_DBL;
            end
         end
         mexp_pkg::ST_DBL: begin
            if (mul_bit) begin
               state_in = mexp_pkg::ST_ADD;
            end else if (all_done) begin
               state_in = mexp_pkg::ST_DONE;
            end
         end
         mexp_pkg::ST_ADD: begin
            state_in = all_done ? mexp_pkg::ST_DONE : mexp_pkg::ST_DBL;
         end
         mexp_pkg::ST_DONE: begin
            if (rsp_ch.ready) begin
               state_in = mexp_pkg::ST_IDLE;
            end
         end
         default: state_in = mexp_pkg::ST_IDLE;
      endcase
   end

   // Datapath next values
   always_comb begin
      phase_in   = phase_ff;
      prod_in    = prod_ff;
      mul_a_in   = mul_a_ff;
      mul_b_in   = mul_b_ff;
      cnt_in     = cnt_ff;
      exp_in     = exp_ff;
      exp_cnt_in = exp_cnt_ff;
      base_in    = base_ff;
      result_in  = result_ff;
      case (state_ff)
         mexp_pkg::ST_IDLE: begin
            // Load: reduce the message first, as message * 1 mod modulus
            if (req_ch.valid) begin
               result_in  = WORD_ZERO;
               phase_in   = mexp_pkg::PH_REDUCE;
               prod_in    = WORD_ZERO;
               mul_a_in   = WORD_ONE;
               mul_b_in   = msg_word;
               cnt_in     = CNT_LAST;
               exp_in     = exponent_ff;
               exp_cnt_in = CNT_LAST;
            end
         end
         mexp_pkg::ST_DBL, mexp_pkg::ST_ADD: begin
            prod_in = unit_out;
            // Advance to the next multiplier bit unless an add is pending
            if (!((state_ff == mexp_pkg::ST_DBL) && mul_bit)) begin
               mul_b_in = mul_b_ff << 1;
               cnt_in   = cnt_ff - CNT_W'(1);
            end
            if (mul_done) begin
               case (phase_ff)
                  mexp_pkg::PH_REDUCE: begin
                     // Start squaring from an accumulator of one
                     base_in  = unit_out;
                     phase_in = mexp_pkg::PH_SQUARE;
                     prod_in  = WORD_ZERO;
                     mul_a_in = WORD_ONE;
                     mul_b_in = WORD_ONE;
                     cnt_in   = CNT_LAST;
                  end
                  mexp_pkg::PH_SQUARE, mexp_pkg::PH_MULT: begin
                     if ((phase_ff == mexp_pkg::PH_SQUARE) && exp_bit) begin
                        // Set exponent bit: multiply by the base
                        phase_in = mexp_pkg::PH_MULT;
                        prod_in  = WORD_ZERO;
                        mul_a_in = unit_out;
                        mul_b_in = base_ff;
                        cnt_in   = CNT_LAST;
                     end else begin
                        // Drop the finished exponent bit
                        exp_in     = exp_ff << 1;
                        exp_cnt_in = exp_cnt_ff - CNT_W'(1);
                        if (exp_last) begin
                           result_in = unit_out;
                        end else begin
                           phase_in = mexp_pkg::PH_SQUARE;
                           prod_in  = WORD_ZERO;
                           mul_a_in = unit_out;
                           mul_b_in = unit_out;
                           cnt_in   = CNT_LAST;
                        end
                     end
                  end
                  default: phase_in = mexp_pkg::PH_REDUCE;
               endcase
            end
         end
         default: begin
            // Hold the result until it is transferred
            result_in = result_ff;
         end
      endcase
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mexp_pkg::ST_IDLE;
         phase_ff <= mexp_pkg::PH_REDUCE;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff    <= prod_in;
      mul_a_ff   <= mul_a_in;
      mul_b_ff   <= mul_b_in;
      cnt_ff     <= cnt_in;
      exp_ff     <= exp_in;
      exp_cnt_ff <= exp_cnt_in;
      base_ff    <= base_in;
      result_ff  <= result_in;
   end

   // Channel outputs
   always_comb begin
      req_ch.ready  = (state_ff == mexp_pkg::ST_IDLE);
      rsp_ch.valid  = (state_ff == mexp_pkg::ST_DONE);
      rsp_ch.result = result_wide[mexp_pkg::RESULT_WIDTH-1:0];
   end

   // Checks
   `MEXP_ASSERT(a_one_side_busy, !(req_ch.ready && rsp_ch.valid), "request and response both open")
   `MEXP_ASSERT(a_busy_after_take, (req_ch.valid && req_ch.ready) |=> !req_ch.ready, "request taken while busy")
   `MEXP_ASSERT(a_prod_reduced, ((state_ff == mexp_pkg::ST_DBL) || (state_ff == mexp_pkg::ST_ADD)) |-> (prod_ff < modulus_ff), "partial product not reduced")
   `MEXP_ASSERT(a_result_reduced, (rsp_ch.valid && !modulus_small) |-> (result_ff < modulus_ff), "result not below modulus")

endmodule
